[rtl/qla_pkg.sv]
// Shared types and constants for the tabular Q-learning agent.
// Used by every module of the block; depends on nothing.
package qla_pkg;

	localparam int NUM_STATES_DEF  = 9;
	localparam int NUM_ACTIONS_DEF = 3;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int INT_BITS        = 16;
	localparam int LEARN_RATE_PCT  = 2;
	localparam int EXPLORE_PCT     = 1;
	localparam int CFG_IDX_W       = 2;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_START = 2'd1,
		KIND_STEP  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARN_RATE = 2'd0,
		REG_DISCOUNT   = 2'd1,
		REG_EXPLORE    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic rd_old;
		logic rd_row;
		logic upd_wr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_start;
		logic is_step;
		logic ld_ok;
		logic st_ok;
		logic explore;
		logic col_last;
		logic same_row;
	} sts_t;

endpackage

[rtl/qla_ctrl.sv]
// Sequencer for the Q-learning agent: steps items through decode, row scan,
// update arithmetic and result hand-off as their kind needs. Depends on qla_pkg.
module qla_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_free,
	input  qla_pkg::sts_t sts,
	output qla_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_DECODE   = 11'b000_0000_0010,
		S_OLD      = 11'b000_0000_0100,
		S_SCAN     = 11'b000_0000_1000,
		S_SCAN_END = 11'b000_0001_0000,
		S_MUL1     = 11'b000_0010_0000,
		S_MUL2     = 11'b000_0100_0000,
		S_MUL3     = 11'b000_1000_0000,
		S_MUL4     = 11'b001_0000_0000,
		S_WRITE    = 11'b010_0000_0000,
		S_DONE     = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   pass_q, pass_d;

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				pass_d = 1'b0;
				if (sts.is_load) begin
					cmd.load_wr = sts.ld_ok;
					state_d     = S_IDLE;
				end else if (sts.st_ok && sts.is_step) begin
					state_d = S_OLD;
				end else if (sts.st_ok && sts.is_start) begin
					state_d = sts.explore ? S_DONE : S_SCAN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OLD: begin
				cmd.rd_old = 1'b1;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				cmd.rd_row = 1'b1;
				if (sts.col_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = (pass_q || sts.is_start) ? S_DONE : S_MUL1;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_MUL4;
			S_MUL4: state_d = S_WRITE;
			S_WRITE: begin
				cmd.upd_wr = 1'b1;
				if (sts.same_row && !sts.explore) begin
					pass_d  = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

endmodule

[rtl/qla_dp.sv]
// Datapath of the Q-learning agent: item capture, value memory, row max and
// argmax scan, update multiply pipeline and action choice. Depends on qla_pkg.
module qla_dp #(
	parameter int NUM_STATES  = qla_pkg::NUM_STATES_DEF,
	parameter int NUM_ACTIONS = qla_pkg::NUM_ACTIONS_DEF,
	parameter int FRAC_BITS   = qla_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qla_pkg::cmd_t                         cmd,
	output qla_pkg::sts_t                         sts,
	input  logic [1:0]                            kind,
	input  logic [$clog2(NUM_STATES)-1:0]         state_index,
	input  logic [$clog2(NUM_ACTIONS)-1:0]        action_index,
	input  logic [qla_pkg::INT_BITS+FRAC_BITS-1:0] load_value,
	input  logic [FRAC_BITS:0]                    reward,
	input  logic [FRAC_BITS-1:0]                  random_draw,
	input  logic [$clog2(NUM_ACTIONS)-1:0]        random_action,
	input  logic [FRAC_BITS:0]                    learn_rate,
	input  logic [FRAC_BITS:0]                    discount,
	input  logic [FRAC_BITS:0]                    explore_threshold,
	output logic [$clog2(NUM_ACTIONS)-1:0]        res_action,
	output logic                                  res_explored,
	output logic [qla_pkg::INT_BITS+FRAC_BITS-1:0] res_value
);

	localparam int VW    = qla_pkg::INT_BITS + FRAC_BITS;
	localparam int CW    = FRAC_BITS + 1;
	localparam int SW    = $clog2(NUM_STATES);
	localparam int AIW   = $clog2(NUM_ACTIONS);
	localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
	localparam int ADW   = $clog2(DEPTH);
	localparam int TW    = VW + 1;
	localparam int PGW   = CW + VW;
	localparam int PAW   = CW + TW;
	localparam int SUMW  = PAW + 1;

	localparam logic [CW-1:0]  ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [ADW-1:0] NA_ADR = ADW'(NUM_ACTIONS);

	qla_pkg::kind_t   kind_q;
	logic [SW-1:0]    st_q;
	logic [AIW-1:0]   act_q;
	logic [VW-1:0]    load_q;
	logic [CW-1:0]    reward_q;
	logic [FRAC_BITS-1:0] draw_q;
	logic [AIW-1:0]   ract_q;

	logic [SW-1:0]    last_state_q;
	logic [AIW-1:0]   last_action_q;
	logic [AIW-1:0]   col_q;
	logic             old_s1;
	logic             row_s1;
	logic [AIW-1:0]   col_s1;
	logic [VW-1:0]    rd_data_s1;
	logic [VW-1:0]    q_old_q;
	logic [VW-1:0]    best_q;
	logic [AIW-1:0]   pick_q;
	logic [VW-1:0]    written_q;

	logic [PGW-1:0]   prod_g_s1;
	logic [TW-1:0]    target_s2;
	logic [PAW-1:0]   prod_a_s3;
	logic [PAW-1:0]   prod_b_s3;
	logic [VW-1:0]    nv_s4;

	logic [VW-1:0]    mem [DEPTH];

	logic [CW-1:0]    alpha;
	logic [CW-1:0]    gamma;
	logic [CW-1:0]    one_minus;
	logic [ADW-1:0]   row_base;
	logic [ADW-1:0]   row_addr;
	logic [ADW-1:0]   load_addr;
	logic [ADW-1:0]   last_addr;
	logic [ADW-1:0]   rd_addr;
	logic [SUMW-1:0]  sum;
	logic [SUMW-1:0]  shr;
	logic [VW-1:0]    nv;
	logic [AIW-1:0]   ract_red;
	logic [AIW-1:0]   choice;

	assign alpha     = (learn_rate > ONE) ? ONE : learn_rate;
	assign gamma     = (discount > ONE) ? ONE : discount;
	assign one_minus = ONE - alpha;

	assign row_base  = ADW'(st_q) * NA_ADR;
	assign row_addr  = row_base + ADW'(col_q);
	assign load_addr = row_base + ADW'(act_q);
	assign last_addr = ADW'(last_state_q) * NA_ADR + ADW'(last_action_q);
	assign rd_addr   = cmd.rd_old ? last_addr : row_addr;

	assign sum = SUMW'(prod_a_s3) + SUMW'(prod_b_s3);
	assign shr = sum >> FRAC_BITS;
	assign nv  = (|shr[SUMW-1:VW]) ? {VW{1'b1}} : shr[VW-1:0];

	assign ract_red = ({1'b0, ract_q} >= (AIW+1)'(NUM_ACTIONS))
		? AIW'({1'b0, ract_q} - (AIW+1)'(NUM_ACTIONS)) : ract_q;
	assign choice   = sts.explore ? ract_red : pick_q;

	always_comb begin
		sts          = '0;
		unique case (kind_q)
			qla_pkg::KIND_LOAD:  sts.is_load  = 1'b1;
			qla_pkg::KIND_START: sts.is_start = 1'b1;
			qla_pkg::KIND_STEP:  sts.is_step  = 1'b1;
			default: ;
		endcase
		sts.st_ok    = {1'b0, st_q} < (SW+1)'(NUM_STATES);
		sts.ld_ok    = sts.st_ok && ({1'b0, act_q} < (AIW+1)'(NUM_ACTIONS));
		sts.explore  = {1'b0, draw_q} < explore_threshold;
		sts.col_last = col_q == AIW'(NUM_ACTIONS - 1);
		sts.same_row = last_state_q == st_q;
	end

	assign res_action   = choice;
	assign res_explored = sts.explore;
	assign res_value    = written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q  <= '0;
			last_action_q <= '0;
			col_q         <= '0;
			old_s1        <= 1'b0;
			row_s1        <= 1'b0;
		end else begin
			old_s1 <= cmd.rd_old;
			row_s1 <= cmd.rd_row;
			if (cmd.rd_row) begin
				col_q <= sts.col_last ? '0 : col_q + 1'b1;
			end
			if (cmd.emit) begin
				last_state_q  <= st_q;
				last_action_q <= choice;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= qla_pkg::kind_t'(kind);
			st_q     <= state_index;
			act_q    <= action_index;
			load_q   <= load_value;
			reward_q <= reward;
			draw_q   <= random_draw;
			ract_q   <= random_action;
		end
		if (cmd.capture) begin
			written_q <= '0;
		end else if (cmd.upd_wr) begin
			written_q <= nv_s4;
		end
		col_s1 <= col_q;
		if (old_s1) begin
			q_old_q <= rd_data_s1;
		end
		if (row_s1 && (col_s1 == '0 || rd_data_s1 > best_q)) begin
			best_q <= rd_data_s1;
			pick_q <= col_s1;
		end
		prod_g_s1 <= PGW'(gamma) * PGW'(best_q);
		target_s2 <= TW'(reward_q) + TW'(prod_g_s1 >> FRAC_BITS);
		prod_a_s3 <= PAW'(one_minus) * PAW'(q_old_q);
		prod_b_s3 <= PAW'(alpha) * PAW'(target_s2);
		nv_s4     <= nv;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem[load_addr] <= load_q;
		end else if (cmd.upd_wr) begin
			mem[last_addr] <= nv_s4;
		end
		if (cmd.rd_old || cmd.rd_row) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

[rtl/tabular_q_learning_agent_core.sv]
// A load item writes the table in decode when its indices are in range. A start item that
// explores skips the row scan; a non-exploring step rescans when it updated the new row.
// A new item is taken only once the last is done and any result handed off. The single-port
// value memory reads one entry a cycle; the update multiply pipeline has four stages.
// Reset clears control, last state and action, and loads default registers;
// the value table is undefined until loaded and has no clearing pass.
module tabular_q_learning_agent_core #(
	parameter int NUM_STATES  = qla_pkg::NUM_STATES_DEF,
	parameter int NUM_ACTIONS = qla_pkg::NUM_ACTIONS_DEF,
	parameter int FRAC_BITS   = qla_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             kind,
	input  logic [$clog2(NUM_STATES)-1:0]          state_index,
	input  logic [$clog2(NUM_ACTIONS)-1:0]         action_index,
	input  logic [qla_pkg::INT_BITS+FRAC_BITS-1:0] load_value,
	input  logic [FRAC_BITS:0]                     reward,
	input  logic [FRAC_BITS-1:0]                   random_draw,
	input  logic [$clog2(NUM_ACTIONS)-1:0]         random_action,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [$clog2(NUM_ACTIONS)-1:0]         chosen_action,
	output logic                                   explored,
	output logic [qla_pkg::INT_BITS+FRAC_BITS-1:0] updated_value,
	input  logic                                   cfg_we,
	input  logic [qla_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [FRAC_BITS:0]                     cfg_data
);

	localparam int VW  = qla_pkg::INT_BITS + FRAC_BITS;
	localparam int CW  = FRAC_BITS + 1;
	localparam int AIW = $clog2(NUM_ACTIONS);
	localparam int LR_RESET  = ((qla_pkg::LEARN_RATE_PCT << FRAC_BITS) + 50) / 100;
	localparam int EPS_RESET = ((qla_pkg::EXPLORE_PCT << FRAC_BITS) + 50) / 100;

	qla_pkg::cmd_t cmd;
	qla_pkg::sts_t sts;

	logic [CW-1:0]  learn_rate_q;
	logic [CW-1:0]  discount_q;
	logic [CW-1:0]  explore_threshold_q;
	logic           out_valid_q;
	logic [AIW-1:0] chosen_action_q;
	logic           explored_q;
	logic [VW-1:0]  updated_value_q;
	logic           out_free;
	logic [AIW-1:0] res_action;
	logic           res_explored;
	logic [VW-1:0]  res_value;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q        <= CW'(LR_RESET);
			discount_q          <= '0;
			explore_threshold_q <= CW'(EPS_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				qla_pkg::REG_LEARN_RATE: learn_rate_q        <= cfg_data;
				qla_pkg::REG_DISCOUNT:   discount_q          <= cfg_data;
				qla_pkg::REG_EXPLORE:    explore_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	qla_dp #(
		.NUM_STATES  (NUM_STATES),
		.NUM_ACTIONS (NUM_ACTIONS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.kind              (kind),
		.state_index       (state_index),
		.action_index      (action_index),
		.load_value        (load_value),
		.reward            (reward),
		.random_draw       (random_draw),
		.random_action     (random_action),
		.learn_rate        (learn_rate_q),
		.discount          (discount_q),
		.explore_threshold (explore_threshold_q),
		.res_action        (res_action),
		.res_explored      (res_explored),
		.res_value         (res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			chosen_action_q <= res_action;
			explored_q      <= res_explored;
			updated_value_q <= res_value;
		end
	end

	assign out_valid     = out_valid_q;
	assign chosen_action = chosen_action_q;
	assign explored      = explored_q;
	assign updated_value = updated_value_q;

endmodule

[rtl/qla_checker.sv]
// Port-level checks for the Q-learning agent core, bound to the top level.
// Depends on qla_pkg and tabular_q_learning_agent_core.
module qla_checker #(
	parameter int NUM_ACTIONS = qla_pkg::NUM_ACTIONS_DEF,
	parameter int FRAC_BITS   = qla_pkg::FRAC_BITS_DEF
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic [1:0]                             kind,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [$clog2(NUM_ACTIONS)-1:0]         chosen_action,
	input logic                                   explored,
	input logic [qla_pkg::INT_BITS+FRAC_BITS-1:0] updated_value
);

	localparam int AIW = $clog2(NUM_ACTIONS);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chosen_action)
			&& $stable(explored) && $stable(updated_value))
		else $error("result changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready held through a transfer");

	a_load_turnaround: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == qla_pkg::KIND_LOAD |=> ##1 in_ready)
		else $error("load item did not release input");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, chosen_action} < (AIW+1)'(NUM_ACTIONS))
		else $error("chosen action out of range");

endmodule

bind tabular_q_learning_agent_core qla_checker #(
	.NUM_ACTIONS (NUM_ACTIONS),
	.FRAC_BITS   (FRAC_BITS)
) u_qla_checker (.*);
